// ----- sv/fstr_pkg.sv -----
// ============================================================================
// Flame subpixel tone-map resolve: shared package
// Widths, register indexes, reset values and the exp2 factor table.
// ============================================================================
package fstr_pkg;

    // Default field widths
    localparam int DEF_COUNT_BITS = 24;
    localparam int DEF_SUM_BITS   = 32;

    // Width of each operand of the shared multiplier
    localparam int MUL_W = 33;

    // Configuration register indexes
    localparam logic [1:0] REG_LOG_GAIN  = 2'd0;
    localparam logic [1:0] REG_INV_GAMMA = 2'd1;
    localparam logic [1:0] REG_VIBRANCY  = 2'd2;
    localparam logic [1:0] REG_SCALE     = 2'd3;

    // Register reset values
    localparam logic [15:0] RST_LOG_GAIN  = 16'd256;
    localparam logic [15:0] RST_INV_GAMMA = 16'd1024;
    localparam logic [16:0] RST_VIBRANCY  = 17'd65536;
    localparam logic [31:0] RST_SCALE     = 32'd1;

    // Fixed-point constants
    localparam logic [16:0] Q_ONE       = 17'd65536;
    localparam logic [14:0] LOG10_2_Q16 = 15'd19728;
    localparam logic [18:0] ACC_MAX     = 19'h7FFFF;
    localparam logic [18:0] DIM_LIMIT   = 19'd256;

    typedef logic [15:0][30:0] fac_tab_t;

    // Floor square root, evaluated only at elaboration.
    function automatic logic [63:0] isqrt64(input logic [63:0] v);
        logic [63:0] r;
        logic [63:0] b;
        logic [63:0] rem;
        r   = '0;
        b   = 64'd1 << 62;
        rem = v;
        for (int i = 0; i < 32; i++) begin
            if (b > rem) begin
                b = b >> 2;
            end
        end
        for (int i = 0; i < 32; i++) begin
            if (b != 0) begin
                if (rem >= r + b) begin
                    rem = rem - (r + b);
                    r   = (r >> 1) + b;
                end else begin
                    r = r >> 1;
                end
                b = b >> 2;
            end
        end
        return r;
    endfunction

    // Entry k holds 2^(2^(k-16)) in Q1.30, each the floor root of the one above.
    function automatic fac_tab_t exp_factors();
        fac_tab_t    t;
        logic [63:0] f;
        f     = isqrt64(64'd2 << 60);
        t[15] = f[30:0];
        for (int k = 14; k >= 0; k--) begin
            f    = isqrt64({3'b000, t[k+1], 30'd0});
            t[k] = f[30:0];
        end
        return t;
    endfunction

    localparam fac_tab_t EXP_FAC = exp_factors();

endpackage

// ----- sv/flame_subpixel_tonemap_resolve_core.sv -----
// ============================================================================
// Flame subpixel tone-map resolve core
// Log-density tone mapping of histogram subpixels and 2x2 resolve to RGBA.
// ============================================================================
// Usage. Each transaction on the s_axis channel carries one histogram
// subpixel: three color sums and a hit count in tdata, and tlast set on the
// fourth subpixel of a pixel. Only a transaction with tlast produces an
// m_axis transaction, one RGBA byte quadruple; the others only add into the
// pixel sums. Settings are written through cfg_we/cfg_addr/cfg_wdata while
// the core is idle.
// Timing. One sequencer drives one shared multiplier and one bit-serial
// divider. For a subpixel with hits, each log2 runs a six-step normalize
// and a 16-step squaring loop on the multiplier, each power adds a 16-step
// exp2 loop, and the four divisions produce one quotient bit per cycle
// (max(SUM_BITS+16, 48) bits). The last subpixel adds the three final
// divisions unless alpha is below DIM_LIMIT. s_axis_tready is high only
// between items.
// Reset clears the pixel sums, loads the register defaults and empties the
// output register. A stalled receiver holds the result in the output
// register; the next subpixels are still taken, and only a further result
// waits until the register is free.
// ============================================================================
module flame_subpixel_tonemap_resolve_core #(
    parameter int COUNT_BITS = fstr_pkg::DEF_COUNT_BITS,
    parameter int SUM_BITS   = fstr_pkg::DEF_SUM_BITS,
    localparam int IN_W = ((3 * SUM_BITS + COUNT_BITS + 7) / 8) * 8
) (
    input  logic            clk,
    input  logic            rst_n,
    // Fields from bit 0 up: red_sum, green_sum, blue_sum, hit_count, zero pad
    input  logic [IN_W-1:0] s_axis_tdata,
    input  logic            s_axis_tvalid,
    input  logic            s_axis_tlast,
    output logic            s_axis_tready,
    // Fields from bit 0 up: red_out, green_out, blue_out, alpha_out
    output logic [31:0]     m_axis_tdata,
    output logic            m_axis_tvalid,
    input  logic            m_axis_tready,
    input  logic            cfg_we,
    input  logic [1:0]      cfg_addr,
    input  logic [31:0]     cfg_wdata
);

    import fstr_pkg::*;

    localparam int DIV_N_W = (SUM_BITS + 16 > 48) ? SUM_BITS + 16 : 48;
    localparam int DIV_D_W = (COUNT_BITS + 8 > 32) ? COUNT_BITS + 8 : 32;

    typedef enum logic [4:0] {
        S_IDLE, S_PROD, S_NORM, S_SQR, S_LOGRET, S_L10, S_DMUL,
        S_POWMAG, S_POWSET, S_EXP, S_POWFIN, S_POWRET,
        S_GFDIV, S_GFWAIT, S_CDIV, S_CWAIT, S_LMUL, S_BMUL, S_BLEND,
        S_WMUL, S_ALPHA, S_FIN, S_FDIV, S_FWAIT, S_EMIT
    } state_t;

    state_t state_reg;

    // Settings
    logic [15:0] gain_reg;
    logic [15:0] gamma_reg;
    logic [16:0] vib_reg;
    logic [31:0] scale_reg;

    // Current subpixel
    logic [SUM_BITS-1:0]   sum_reg [3];
    logic [COUNT_BITS-1:0] cnt_reg;
    logic                  last_reg;

    // Log2 / power working registers
    logic [63:0]        x_reg;
    logic [5:0]         lz_reg;
    logic [2:0]         step_reg;
    logic [30:0]        m_reg;
    logic [15:0]        frac_reg;
    logic [3:0]         it_reg;
    logic signed [22:0] lg_reg;
    logic               pow_mode_reg;   // 0: density log, 1: power
    logic               pow_z_reg;      // power result goes to w, else to a
    logic               neg_reg;
    logic [24:0]        magn_reg;
    logic [4:0]         ip_reg;
    logic [15:0]        f_reg;
    logic [30:0]        r_reg;
    logic [31:0]        pw_reg;

    // Tone values
    logic [20:0] l10_reg;
    logic [31:0] d_reg;
    logic [31:0] gf_reg;
    logic [16:0] w_reg;
    logic [31:0] c_reg;
    logic [31:0] l_reg;
    logic [31:0] a_reg;
    logic [31:0] b_reg;
    logic [16:0] bl_reg;
    logic [1:0]  ch_reg;

    // Pixel sums and result
    logic [18:0]      acc_reg [3];
    logic [18:0]      alpha_reg;
    logic [3:0][7:0]  res_reg;
    logic [31:0]      out_reg;
    logic             out_valid_reg;

    // Shared multiplier
    logic [MUL_W-1:0]   mul_a;
    logic [MUL_W-1:0]   mul_b;
    logic [2*MUL_W-1:0] prod;

    // Divider
    logic               div_start;
    logic [DIV_N_W-1:0] div_num;
    logic [DIV_D_W-1:0] div_den;
    logic               div_done;
    logic [DIV_N_W-1:0] div_q;
    logic [31:0]        div_q_sat;

    // Combinational helpers
    logic [63:0]  nx;
    logic [5:0]   nlz;
    logic [31:0]  sq_t;
    logic [6:0]   pq;
    logic [22:0]  lg_new;
    logic [21:0]  mag;
    logic [64:0]  dens;
    logic [28:0]  d_new;
    logic [8:0]   ipw;
    logic [9:0]   ipn;
    logic [15:0]  fneg;
    logic [63:0]  pos_sh;
    logic [63:0]  neg_sh;
    logic [31:0]  pow_out;
    logic         b_ge_a;
    logic [31:0]  diff_ab;
    logic [49:0]  a_sh;
    logic [33:0]  u_pos;
    logic [49:0]  v_neg;
    logic [16:0]  blend_val;
    logic [16:0]  w_add;
    logic [19:0]  acc_sum;
    logic [19:0]  alpha_sum;
    logic [SUM_BITS-1:0] sum_sel;
    logic [18:0]  acc_sel;
    logic [23:0]  byte_tmp;
    logic [26:0]  alpha_tmp;
    logic [47:0]  hi_prod;
    logic [31:0]  hi_sat;

    always_comb
    begin
        unique case (ch_reg)
            2'd0:    begin sum_sel = sum_reg[0]; acc_sel = acc_reg[0]; end
            2'd1:    begin sum_sel = sum_reg[1]; acc_sel = acc_reg[1]; end
            2'd2:    begin sum_sel = sum_reg[2]; acc_sel = acc_reg[2]; end
            default: begin sum_sel = '0;         acc_sel = '0;         end
        endcase
    end

    assign mag = lg_reg[22] ? 22'(-lg_reg) : lg_reg[21:0];

    // Operand selection for the one multiplier.
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            S_PROD:   begin mul_a = MUL_W'(cnt_reg);   mul_b = MUL_W'(scale_reg);   end
            S_SQR:    begin mul_a = MUL_W'(m_reg);     mul_b = MUL_W'(m_reg);       end
            S_L10:    begin mul_a = MUL_W'(lg_reg[21:0]); mul_b = MUL_W'(LOG10_2_Q16); end
            S_DMUL:   begin mul_a = MUL_W'(gain_reg);  mul_b = MUL_W'(l10_reg);     end
            S_POWMAG: begin mul_a = MUL_W'(mag);       mul_b = MUL_W'(gamma_reg);   end
            S_EXP:    begin mul_a = MUL_W'(r_reg);     mul_b = MUL_W'(EXP_FAC[it_reg]); end
            S_LMUL:   begin mul_a = MUL_W'(d_reg);     mul_b = MUL_W'(c_reg);       end
            S_BMUL:   begin mul_a = MUL_W'(gf_reg);    mul_b = MUL_W'(l_reg);       end
            S_BLEND:  begin mul_a = MUL_W'(vib_reg);   mul_b = MUL_W'(diff_ab);     end
            S_WMUL:   begin mul_a = MUL_W'(w_reg);     mul_b = MUL_W'(bl_reg);      end
            default:  begin mul_a = '0;                mul_b = '0;                  end
        endcase
    end

    assign prod = mul_a * mul_b;

    // Normalize: six shift steps of 32, 16, 8, 4, 2 and 1 bits.
    always_comb
    begin
        nx  = x_reg;
        nlz = lz_reg;
        unique case (step_reg)
            3'd5: if (x_reg[63:32] == '0) begin nx = x_reg << 32; nlz = lz_reg + 6'd32; end
            3'd4: if (x_reg[63:48] == '0) begin nx = x_reg << 16; nlz = lz_reg + 6'd16; end
            3'd3: if (x_reg[63:56] == '0) begin nx = x_reg << 8;  nlz = lz_reg + 6'd8;  end
            3'd2: if (x_reg[63:60] == '0) begin nx = x_reg << 4;  nlz = lz_reg + 6'd4;  end
            3'd1: if (x_reg[63:62] == '0) begin nx = x_reg << 2;  nlz = lz_reg + 6'd2;  end
            3'd0: if (!x_reg[63])         begin nx = x_reg << 1;  nlz = lz_reg + 6'd1;  end
            default: ;
        endcase
    end

    always_comb
    begin
        sq_t   = prod[61:30];
        pq     = {1'b0, 6'd63 - lz_reg} - (pow_mode_reg ? 7'd16 : 7'd32);
        lg_new = {pq, frac_reg};
        dens   = {1'b0, prod[63:0]} + (65'd1 << 32);
        d_new  = prod[36:8];

        // Power: integer and fraction parts of g * log2(x)
        ipw  = magn_reg[24:16];
        ipn  = {1'b0, ipw} + 10'd1;
        fneg = 16'(~magn_reg[15:0] + 16'd1);

        pos_sh  = (64'(r_reg) << ip_reg[3:0]) >> 14;
        neg_sh  = 64'(r_reg) >> (6'd14 + {1'b0, ip_reg});
        pow_out = neg_reg ? neg_sh[31:0]
                          : ((pos_sh[63:32] != '0) ? 32'hFFFF_FFFF : pos_sh[31:0]);

        hi_prod = prod[63:16];
        hi_sat  = (hi_prod[47:32] != '0) ? 32'hFFFF_FFFF : hi_prod[31:0];

        // Vibrancy blend a + v*(b - a), clamped to [0, 1]
        b_ge_a  = b_reg >= a_reg;
        diff_ab = b_ge_a ? (b_reg - a_reg) : (a_reg - b_reg);
        a_sh    = {2'b00, a_reg, 16'd0};
        u_pos   = 34'(a_reg) + 34'(prod[49:16]);
        v_neg   = a_sh - prod[49:0];
        if (b_ge_a)
        begin
            blend_val = (u_pos > 34'(Q_ONE)) ? Q_ONE : u_pos[16:0];
        end
        else if (prod[49:0] >= a_sh)
        begin
            blend_val = '0;
        end
        else
        begin
            blend_val = (v_neg[49:16] > 34'(Q_ONE)) ? Q_ONE : v_neg[32:16];
        end

        w_add     = prod[32:16];
        acc_sum   = {1'b0, acc_sel} + 20'(w_add);
        alpha_sum = {1'b0, alpha_reg} + 20'(w_reg);

        div_q_sat = (div_q[DIV_N_W-1:32] != '0) ? 32'hFFFF_FFFF : div_q[31:0];
        byte_tmp  = {div_q[15:0], 8'd0} - div_q[23:0];
        alpha_tmp = {alpha_reg, 8'd0} - 27'(alpha_reg);
    end

    // Divider operands
    always_comb
    begin
        div_start = 1'b0;
        div_num   = '0;
        div_den   = '0;
        unique case (state_reg)
            S_GFDIV:
            begin
                div_start = 1'b1;
                div_num   = DIV_N_W'({pw_reg, 16'd0});
                div_den   = DIV_D_W'(d_reg);
            end
            S_CDIV:
            begin
                div_start = 1'b1;
                div_num   = DIV_N_W'({sum_sel, 16'd0});
                div_den   = DIV_D_W'({cnt_reg, 8'd0}) - DIV_D_W'(cnt_reg);
            end
            S_FDIV:
            begin
                div_start = 1'b1;
                div_num   = DIV_N_W'({acc_sel, 16'd0});
                div_den   = DIV_D_W'(alpha_reg);
            end
            default: ;
        endcase
    end

    fstr_div #(
        .N_W (DIV_N_W),
        .D_W (DIV_D_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_num),
        .divisor  (div_den),
        .done     (div_done),
        .quotient (div_q)
    );

    // The user must write settings only while the core is idle; the block itself does not enforce it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg  <= RST_LOG_GAIN;
            gamma_reg <= RST_INV_GAMMA;
            vib_reg   <= RST_VIBRANCY;
            scale_reg <= RST_SCALE;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_LOG_GAIN:  gain_reg  <= cfg_wdata[15:0];
                REG_INV_GAMMA: gamma_reg <= cfg_wdata[15:0];
                REG_VIBRANCY:  vib_reg   <= cfg_wdata[16:0];
                REG_SCALE:     scale_reg <= cfg_wdata;
            endcase
        end
    end

    // Sequencer with its datapath registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            acc_reg[0]    <= '0;
            acc_reg[1]    <= '0;
            acc_reg[2]    <= '0;
            alpha_reg     <= '0;
            ch_reg        <= '0;
            it_reg        <= '0;
            step_reg      <= '0;
            lz_reg        <= '0;
            pow_mode_reg  <= 1'b0;
            pow_z_reg     <= 1'b0;
            sum_reg[0]    <= '0;
            sum_reg[1]    <= '0;
            sum_reg[2]    <= '0;
            cnt_reg       <= '0;
            last_reg      <= 1'b0;
            x_reg         <= '0;
            m_reg         <= '0;
            frac_reg      <= '0;
            lg_reg        <= '0;
            neg_reg       <= 1'b0;
            magn_reg      <= '0;
            ip_reg        <= '0;
            f_reg         <= '0;
            r_reg         <= '0;
            pw_reg        <= '0;
            l10_reg       <= '0;
            d_reg         <= '0;
            gf_reg        <= '0;
            w_reg         <= '0;
            c_reg         <= '0;
            l_reg         <= '0;
            a_reg         <= '0;
            b_reg         <= '0;
            bl_reg        <= '0;
            res_reg       <= '0;
            out_reg       <= '0;
        end
        else
        begin
            // The output register empties when its transaction completes,
            // unless a new result is loaded in the same cycle.
            if (out_valid_reg && m_axis_tready && (state_reg != S_EMIT))
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (s_axis_tvalid)
                    begin
                        sum_reg[0] <= s_axis_tdata[SUM_BITS-1:0];
                        sum_reg[1] <= s_axis_tdata[2*SUM_BITS-1:SUM_BITS];
                        sum_reg[2] <= s_axis_tdata[3*SUM_BITS-1:2*SUM_BITS];
                        cnt_reg    <= s_axis_tdata[3*SUM_BITS+COUNT_BITS-1:3*SUM_BITS];
                        last_reg   <= s_axis_tlast;
                        if (s_axis_tdata[3*SUM_BITS+COUNT_BITS-1:3*SUM_BITS] != '0)
                        begin
                            state_reg <= S_PROD;
                        end
                        else if (s_axis_tlast)
                        begin
                            state_reg <= S_FIN;
                        end
                    end
                end

                S_PROD:
                begin
                    // One plus count times scale, saturated at the top of Q32.32
                    x_reg        <= dens[64] ? 64'hFFFF_FFFF_FFFF_FFFF : dens[63:0];
                    lz_reg       <= '0;
                    step_reg     <= 3'd5;
                    pow_mode_reg <= 1'b0;
                    state_reg    <= S_NORM;
                end

                S_NORM:
                begin
                    x_reg    <= nx;
                    lz_reg   <= nlz;
                    step_reg <= step_reg - 3'd1;
                    if (step_reg == 3'd0)
                    begin
                        m_reg     <= nx[63:33];
                        frac_reg  <= '0;
                        it_reg    <= '0;
                        state_reg <= S_SQR;
                    end
                end

                S_SQR:
                begin
                    // Square the mantissa; a result of two or more yields a one bit
                    if (sq_t[31])
                    begin
                        m_reg    <= sq_t[31:1];
                        frac_reg <= {frac_reg[14:0], 1'b1};
                    end
                    else
                    begin
                        m_reg    <= sq_t[30:0];
                        frac_reg <= {frac_reg[14:0], 1'b0};
                    end
                    it_reg <= it_reg + 4'd1;
                    if (it_reg == 4'd15)
                    begin
                        state_reg <= S_LOGRET;
                    end
                end

                S_LOGRET:
                begin
                    lg_reg    <= lg_new;
                    state_reg <= pow_mode_reg ? S_POWMAG : S_L10;
                end

                S_L10:
                begin
                    l10_reg   <= prod[36:16];
                    state_reg <= S_DMUL;
                end

                S_DMUL:
                begin
                    d_reg <= 32'(d_new);
                    if (d_new == '0)
                    begin
                        // No density: the subpixel adds nothing
                        state_reg <= last_reg ? S_FIN : S_IDLE;
                    end
                    else
                    begin
                        x_reg        <= 64'(d_new);
                        lz_reg       <= '0;
                        step_reg     <= 3'd5;
                        pow_mode_reg <= 1'b1;
                        pow_z_reg    <= 1'b1;
                        state_reg    <= S_NORM;
                    end
                end

                S_POWMAG:
                begin
                    neg_reg   <= lg_reg[22];
                    magn_reg  <= prod[36:12];
                    state_reg <= S_POWSET;
                end

                S_POWSET:
                begin
                    r_reg  <= 31'd1 << 30;
                    it_reg <= 4'd15;
                    if (!neg_reg)
                    begin
                        if (ipw >= 9'd16)
                        begin
                            pw_reg    <= 32'hFFFF_FFFF;
                            state_reg <= S_POWRET;
                        end
                        else
                        begin
                            ip_reg    <= ipw[4:0];
                            f_reg     <= magn_reg[15:0];
                            state_reg <= S_EXP;
                        end
                    end
                    else if (magn_reg[15:0] != '0)
                    begin
                        if (ipn > 10'd31)
                        begin
                            pw_reg    <= '0;
                            state_reg <= S_POWRET;
                        end
                        else
                        begin
                            ip_reg    <= ipn[4:0];
                            f_reg     <= fneg;
                            state_reg <= S_EXP;
                        end
                    end
                    else if (ipw > 9'd31)
                    begin
                        pw_reg    <= '0;
                        state_reg <= S_POWRET;
                    end
                    else
                    begin
                        ip_reg    <= ipw[4:0];
                        f_reg     <= '0;
                        state_reg <= S_EXP;
                    end
                end

                S_EXP:
                begin
                    if (f_reg[it_reg])
                    begin
                        r_reg <= prod[60:30];
                    end
                    it_reg <= it_reg - 4'd1;
                    if (it_reg == 4'd0)
                    begin
                        state_reg <= S_POWFIN;
                    end
                end

                S_POWFIN:
                begin
                    pw_reg    <= pow_out;
                    state_reg <= S_POWRET;
                end

                S_POWRET:
                begin
                    if (pow_z_reg)
                    begin
                        w_reg     <= (pw_reg > 32'(Q_ONE)) ? Q_ONE : pw_reg[16:0];
                        state_reg <= S_GFDIV;
                    end
                    else
                    begin
                        a_reg     <= pw_reg;
                        state_reg <= S_BMUL;
                    end
                end

                S_GFDIV:
                begin
                    state_reg <= S_GFWAIT;
                end

                S_GFWAIT:
                begin
                    if (div_done)
                    begin
                        gf_reg    <= div_q_sat;
                        ch_reg    <= 2'd0;
                        state_reg <= S_CDIV;
                    end
                end

                S_CDIV:
                begin
                    state_reg <= S_CWAIT;
                end

                S_CWAIT:
                begin
                    if (div_done)
                    begin
                        c_reg     <= div_q_sat;
                        state_reg <= S_LMUL;
                    end
                end

                S_LMUL:
                begin
                    l_reg <= hi_sat;
                    if (hi_sat == '0)
                    begin
                        // A zero channel stays zero under any gamma
                        a_reg     <= '0;
                        state_reg <= S_BMUL;
                    end
                    else
                    begin
                        x_reg        <= 64'(hi_sat);
                        lz_reg       <= '0;
                        step_reg     <= 3'd5;
                        pow_mode_reg <= 1'b1;
                        pow_z_reg    <= 1'b0;
                        state_reg    <= S_NORM;
                    end
                end

                S_BMUL:
                begin
                    b_reg     <= hi_sat;
                    state_reg <= S_BLEND;
                end

                S_BLEND:
                begin
                    bl_reg    <= blend_val;
                    state_reg <= S_WMUL;
                end

                S_WMUL:
                begin
                    unique case (ch_reg)
                        2'd0:    acc_reg[0] <= acc_sum[19] ? ACC_MAX : acc_sum[18:0];
                        2'd1:    acc_reg[1] <= acc_sum[19] ? ACC_MAX : acc_sum[18:0];
                        2'd2:    acc_reg[2] <= acc_sum[19] ? ACC_MAX : acc_sum[18:0];
                        default: ;
                    endcase
                    if (ch_reg == 2'd2)
                    begin
                        state_reg <= S_ALPHA;
                    end
                    else
                    begin
                        ch_reg    <= ch_reg + 2'd1;
                        state_reg <= S_CDIV;
                    end
                end

                S_ALPHA:
                begin
                    alpha_reg <= alpha_sum[19] ? ACC_MAX : alpha_sum[18:0];
                    state_reg <= last_reg ? S_FIN : S_IDLE;
                end

                S_FIN:
                begin
                    ch_reg <= 2'd0;
                    if (alpha_reg < DIM_LIMIT)
                    begin
                        res_reg   <= '0;
                        state_reg <= S_EMIT;
                    end
                    else
                    begin
                        state_reg <= S_FDIV;
                    end
                end

                S_FDIV:
                begin
                    state_reg <= S_FWAIT;
                end

                S_FWAIT:
                begin
                    if (div_done)
                    begin
                        res_reg[ch_reg] <= byte_tmp[23:16];
                        if (ch_reg == 2'd2)
                        begin
                            res_reg[3] <= alpha_tmp[25:18];
                            state_reg  <= S_EMIT;
                        end
                        else
                        begin
                            ch_reg    <= ch_reg + 2'd1;
                            state_reg <= S_FDIV;
                        end
                    end
                end

                S_EMIT:
                begin
                    if (!out_valid_reg || m_axis_tready)
                    begin
                        out_reg       <= res_reg;
                        out_valid_reg <= 1'b1;
                        acc_reg[0]    <= '0;
                        acc_reg[1]    <= '0;
                        acc_reg[2]    <= '0;
                        alpha_reg     <= '0;
                        state_reg     <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_reg;

endmodule

// ----- sv/fstr_div.sv -----
// ============================================================================
// Flame subpixel tone-map resolve: bit-serial divider
// Restoring unsigned division, one quotient bit per cycle.
// ============================================================================
module fstr_div #(
    parameter int N_W = 48,
    parameter int D_W = 32
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic [N_W-1:0] dividend,
    input  logic [D_W-1:0] divisor,
    output logic           done,
    output logic [N_W-1:0] quotient
);

    localparam int CW = $clog2(N_W + 1);

    logic [D_W-1:0] rem_reg;
    logic [N_W-1:0] quo_reg;
    logic [D_W-1:0] den_reg;
    logic [CW-1:0]  cnt_reg;
    logic           busy_reg;
    logic           done_reg;
    logic [D_W:0]   trial;
    logic [D_W:0]   trial_sub;
    logic           fits;

    always_comb
    begin
        trial     = {rem_reg, quo_reg[N_W-1]};
        fits      = trial >= {1'b0, den_reg};
        trial_sub = trial - {1'b0, den_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(N_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            den_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? trial_sub[D_W-1:0] : trial[D_W-1:0];
            quo_reg <= {quo_reg[N_W-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule
